// File: hdl/gb8_pkg.sv
package gb8_pkg;

    localparam int unsigned CELL_SIDE    = 8;
    localparam int unsigned CELL_W       = 3;
    localparam int unsigned STORE_DEPTH  = 2048;
    localparam int unsigned FONT_INDEX_W = 11;
    localparam int unsigned BYTE_W       = 8;
    localparam int unsigned COORD_W      = 16;
    localparam int unsigned ADDR_W       = 16;

    localparam logic [CELL_W-1:0] CELL_LAST = CELL_W'(CELL_SIDE - 1);

    localparam logic OP_FONT_LOAD = 1'b0;
    localparam logic OP_DRAW      = 1'b1;

    typedef enum logic
    {
        ST_IDLE,
        ST_DRAW
    } gb8_state_t;

    // controller -> datapath
    typedef struct packed
    {
        logic write;   // store one font row byte
        logic start;   // latch a draw and fetch glyph row 0
        logic step;    // emit the current cell into the output register
    } gb8_cmd_t;

    // datapath -> controller
    typedef struct packed
    {
        logic slot_free;  // output register empty or being drained
        logic cell_last;  // current cell is the last of the glyph
    } gb8_status_t;

endpackage

// File: hdl/gb8_in_if.sv
interface gb8_in_if
    import gb8_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic                    operation;
    logic [FONT_INDEX_W-1:0] font_index;
    logic [BYTE_W-1:0]       font_row_bits;
    logic [BYTE_W-1:0]       char_code;
    logic signed [COORD_W-1:0] origin_x;
    logic signed [COORD_W-1:0] origin_y;
    logic [BYTE_W-1:0]       ink_color;

    modport source
    (
        output valid, operation, font_index, font_row_bits, char_code,
               origin_x, origin_y, ink_color,
        input  ready
    );

    modport sink
    (
        input  valid, operation, font_index, font_row_bits, char_code,
               origin_x, origin_y, ink_color,
        output ready
    );
endinterface

// File: hdl/gb8_out_if.sv
interface gb8_out_if
    import gb8_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [ADDR_W-1:0] pixel_address;
    logic [BYTE_W-1:0] pixel_color;
    logic              write_enable;
    logic              last_pixel;

    modport source
    (
        output valid, pixel_address, pixel_color, write_enable, last_pixel,
        input  ready
    );

    modport sink
    (
        input  valid, pixel_address, pixel_color, write_enable, last_pixel,
        output ready
    );
endinterface

// File: hdl/gb8_ctrl.sv
module gb8_ctrl
    import gb8_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        operation,
    output logic        in_ready,
    output gb8_cmd_t    cmd,
    input  gb8_status_t status
);

    gb8_state_t state_reg;
    gb8_state_t state_next;
    logic       accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign accept = in_valid && in_ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && (operation == OP_DRAW))
                begin
                    state_next = ST_DRAW;
                end
            end
            ST_DRAW:
            begin
                if (status.slot_free && status.cell_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready  = 1'b0;
        cmd       = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready  = 1'b1;
                cmd.write = in_valid && (operation == OP_FONT_LOAD);
                cmd.start = in_valid && (operation == OP_DRAW);
            end
            ST_DRAW:
            begin
                cmd.step = status.slot_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    // no draw begins without a draw transaction
    a_draw_needs_start: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && !cmd.start) |=> (state_reg == ST_IDLE))
        else $error("draw state entered without a draw transaction");

    // the last cell always returns the sequencer to idle
    a_last_ends_draw: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.step && status.cell_last) |=> (state_reg == ST_IDLE))
        else $error("sequencer kept drawing past the last cell");

endmodule

// File: hdl/gb8_datapath.sv
module gb8_datapath
    import gb8_pkg::*;
#(
    parameter int unsigned GLYPH_ROWS    = 8,
    parameter int unsigned SCREEN_WIDTH  = 320,
    parameter int unsigned SCREEN_HEIGHT = 200,
    parameter int unsigned CHAR_COUNT    = 256
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  gb8_cmd_t                  cmd,
    output gb8_status_t               status,
    input  logic [FONT_INDEX_W-1:0]   font_index,
    input  logic [BYTE_W-1:0]         font_row_bits,
    input  logic [BYTE_W-1:0]         char_code,
    input  logic signed [COORD_W-1:0] origin_x,
    input  logic signed [COORD_W-1:0] origin_y,
    input  logic [BYTE_W-1:0]         ink_color,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [ADDR_W-1:0]         pixel_address,
    output logic [BYTE_W-1:0]         pixel_color,
    output logic                      write_enable,
    output logic                      last_pixel
);

    localparam int unsigned AREA = SCREEN_WIDTH * SCREEN_HEIGHT;

    // font store
    logic [BYTE_W-1:0]       font_mem [STORE_DEPTH];
    logic [BYTE_W-1:0]       rdata_reg;
    logic                    rd_en;
    logic [FONT_INDEX_W-1:0] rd_addr;
    logic [FONT_INDEX_W-1:0] start_index;

    // draw context
    logic [FONT_INDEX_W-1:0] glyph_base_reg;
    logic                    known_reg;
    logic [BYTE_W-1:0]       ink_reg;
    logic [COORD_W:0]        ox_reg;
    logic [COORD_W:0]        px_reg;
    logic [COORD_W:0]        py_reg;
    logic [ADDR_W-1:0]       line_base_reg;
    logic [CELL_W-1:0]       row_reg;
    logic [CELL_W-1:0]       col_reg;

    // output register
    logic                    out_valid_reg;
    logic [ADDR_W-1:0]       addr_reg;
    logic [BYTE_W-1:0]       color_reg;
    logic                    we_reg;
    logic                    last_reg;

    logic                    col_last;
    logic                    on_screen;
    logic                    glyph_bit;
    logic                    cell_we;
    logic [ADDR_W-1:0]       cell_addr;

    assign col_last    = (col_reg == CELL_LAST);
    assign start_index = FONT_INDEX_W'({3'b000, char_code} * FONT_INDEX_W'(GLYPH_ROWS));
    assign rd_en       = cmd.start || (cmd.step && col_last);
    assign rd_addr     = cmd.start ? start_index
                                   : glyph_base_reg + FONT_INDEX_W'(row_reg) + 1'b1;

    always_ff @(posedge clk)
    begin
        if (cmd.write)
        begin
            font_mem[font_index] <= font_row_bits;
        end
        if (rd_en)
        begin
            rdata_reg <= font_mem[rd_addr];
        end
    end

    // bit 7 is the leftmost cell, so column c reads bit ~c
    assign glyph_bit = known_reg && rdata_reg[~col_reg];
    assign on_screen = !px_reg[COORD_W] && (px_reg < (COORD_W+1)'(SCREEN_WIDTH)) &&
                       !py_reg[COORD_W] && (py_reg < (COORD_W+1)'(SCREEN_HEIGHT));
    assign cell_we   = glyph_bit && on_screen;
    assign cell_addr = line_base_reg + px_reg[ADDR_W-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            glyph_base_reg <= start_index;
            known_reg      <= ({1'b0, char_code} < (BYTE_W+1)'(CHAR_COUNT));
            ink_reg        <= ink_color;
            ox_reg         <= {origin_x[COORD_W-1], origin_x};
            px_reg         <= {origin_x[COORD_W-1], origin_x};
            py_reg         <= {origin_y[COORD_W-1], origin_y};
            line_base_reg  <= ADDR_W'(origin_y * $signed(ADDR_W'(SCREEN_WIDTH)));
        end
        else if (cmd.step)
        begin
            if (col_last)
            begin
                px_reg        <= ox_reg;
                py_reg        <= py_reg + 1'b1;
                line_base_reg <= line_base_reg + ADDR_W'(SCREEN_WIDTH);
            end
            else
            begin
                px_reg <= px_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg       <= '0;
            col_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.start)
            begin
                row_reg <= '0;
                col_reg <= '0;
            end
            else if (cmd.step)
            begin
                col_reg <= col_reg + 1'b1;
                if (col_last)
                begin
                    row_reg <= row_reg + 1'b1;
                end
            end

            if (cmd.step)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.step)
        begin
            addr_reg  <= cell_we ? cell_addr : '0;
            color_reg <= cell_we ? ink_reg : '0;
            we_reg    <= cell_we;
            last_reg  <= status.cell_last;
        end
    end

    assign status.slot_free = !out_valid_reg || out_ready;
    assign status.cell_last = (row_reg == CELL_LAST) && col_last;

    assign out_valid     = out_valid_reg;
    assign pixel_address = addr_reg;
    assign pixel_color   = color_reg;
    assign write_enable  = we_reg;
    assign last_pixel    = last_reg;

    // counters wrap to the first cell after the last one
    a_cells_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.step && status.cell_last) |=> (row_reg == '0 && col_reg == '0))
        else $error("cell counters did not wrap after the last cell");

    // a written pixel lands inside the framebuffer
    a_addr_on_screen: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && we_reg) |->
            ((AREA > 32'd65536) || (32'(addr_reg) < AREA)))
        else $error("written pixel outside the framebuffer");

    // a skipped cell carries zero address and color
    a_skip_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !we_reg) |-> (addr_reg == '0 && color_reg == '0))
        else $error("skipped cell carries nonzero payload");

endmodule

// File: hdl/glyph_blitter_8x8_core.sv
// glyph_blitter_8x8_core: 8x8 bitmap font blitter.
//
// cmd_ch takes two kinds of transaction. A font load (operation 0) writes
// font_row_bits into the font store at font_index and yields nothing. A draw
// (operation 1) yields 64 pixel transactions on pix_ch, row by row from the
// top, leftmost cell first; the 64th carries last_pixel. write_enable is set
// where the glyph bit is set and the cell is on screen; otherwise address and
// color are zero. Codes at or above CHAR_COUNT draw blank.
//
// cmd_ch.ready is high only while no draw is in progress. Once a draw is
// accepted the sequencer enters its draw state, and from there one pixel per
// cycle, while pix_ch accepts, leaves through a single output register. When
// pix_ch stalls the cell sequencer freezes and resumes where it stopped;
// nothing is dropped.
//
// Reset clears the sequencer and the output valid. The font store is not
// cleared: every glyph row must be loaded before a draw reads it.
module glyph_blitter_8x8_core
    import gb8_pkg::*;
#(
    parameter int unsigned GLYPH_ROWS    = 8,
    parameter int unsigned SCREEN_WIDTH  = 320,
    parameter int unsigned SCREEN_HEIGHT = 200,
    parameter int unsigned CHAR_COUNT    = 256
)
(
    input logic     clk,
    input logic     rst_n,
    gb8_in_if.sink  cmd_ch,
    gb8_out_if.source pix_ch
);

    gb8_cmd_t    cmd;
    gb8_status_t status;

    // sequencer: idle / drawing, issues write, start and step commands
    gb8_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cmd_ch.valid),
        .operation (cmd_ch.operation),
        .in_ready  (cmd_ch.ready),
        .cmd       (cmd),
        .status    (status)
    );

    // font store, cell counters, clipping, address and output register
    gb8_datapath #(
        .GLYPH_ROWS    (GLYPH_ROWS),
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT),
        .CHAR_COUNT    (CHAR_COUNT)
    ) u_datapath
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .font_index    (cmd_ch.font_index),
        .font_row_bits (cmd_ch.font_row_bits),
        .char_code     (cmd_ch.char_code),
        .origin_x      (cmd_ch.origin_x),
        .origin_y      (cmd_ch.origin_y),
        .ink_color     (cmd_ch.ink_color),
        .out_valid     (pix_ch.valid),
        .out_ready     (pix_ch.ready),
        .pixel_address (pix_ch.pixel_address),
        .pixel_color   (pix_ch.pixel_color),
        .write_enable  (pix_ch.write_enable),
        .last_pixel    (pix_ch.last_pixel)
    );

endmodule
